[rtl/tm_frame_header_checker_unit_assert.svh]
// ---------------------------------------------------------------------------
// tm frame header checker assertion macros
// shared concurrent assertion forms used by the checker rtl
// ---------------------------------------------------------------------------
`ifndef TM_FRAME_HEADER_CHECKER_UNIT_ASSERT_SVH
`define TM_FRAME_HEADER_CHECKER_UNIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define TMFHC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define TMFHC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/tmfhc_pkg.sv]
// ---------------------------------------------------------------------------
// tm frame header checker package
// shared constants, request codes and item types
// ---------------------------------------------------------------------------
package tmfhc_pkg;

  // sizing
  localparam int MAX_IDS          = 4;
  localparam int CHECKED_CHANNELS = 8;
  localparam int NUM_ID_REGS      = 4;
  localparam int ID_W             = 10;
  localparam int CHAN_W           = 3;
  localparam int CNT_W            = 8;
  localparam int ERR_W            = 16;
  localparam int IDC_W            = 3;
  localparam int CFG_IDX_W        = 3;
  localparam int CFG_DATA_W       = 10;
  localparam int IN_DATA_W        = 32;
  localparam int OUT_DATA_W       = 56;
  localparam int CHAN_IDX_W       = (CHECKED_CHANNELS > 1) ? $clog2(CHECKED_CHANNELS) : 1;

  // saturation level of the error counters
  localparam logic [ERR_W-1:0] ERR_MAX = '1;

  // request kind
  typedef enum logic [0:0] {
    REQ_CHECK = 1'b0,
    REQ_CLEAR = 1'b1
  } req_type_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ID_COUNT = 3'd0,
    CFG_SC_ID_0  = 3'd1,
    CFG_SC_ID_1  = 3'd2,
    CFG_SC_ID_2  = 3'd3,
    CFG_SC_ID_3  = 3'd4
  } cfg_reg_t;

  // one input request
  typedef struct packed {
    req_type_t          req_type;
    logic [ID_W-1:0]    craft_id;
    logic [CHAN_W-1:0]  channel_id;
    logic [CNT_W-1:0]   master_count;
    logic [CNT_W-1:0]   channel_count;
  } item_t;

  // one result
  typedef struct packed {
    logic               frame_accepted;
    logic               master_gap;
    logic               channel_gap;
    logic [ERR_W-1:0]   id_errors;
    logic [ERR_W-1:0]   master_errors;
    logic [ERR_W-1:0]   channel_errors;
  } result_t;

  // saturating increment
  function automatic logic [ERR_W-1:0] sat_inc(input logic [ERR_W-1:0] c);
    sat_inc = (c == ERR_MAX) ? c : c + 1'b1;
  endfunction

endpackage

[rtl/tmfhc_id_match.sv]
// ---------------------------------------------------------------------------
// tm frame header checker spacecraft id match
// compares the header id against the active configured id entries
// ---------------------------------------------------------------------------
module tmfhc_id_match (
  input  logic [tmfhc_pkg::IDC_W-1:0]                         id_count,
  input  logic [tmfhc_pkg::NUM_ID_REGS-1:0][tmfhc_pkg::ID_W-1:0] sc_ids,
  input  logic [tmfhc_pkg::ID_W-1:0]                          craft_id,
  output logic                                                hit
);
  import tmfhc_pkg::*;

  // entry i is live when i is below id_count; only MAX_IDS entries are looked at,
  // which caps an oversized count
  always_comb begin
    hit = 1'b0;
    for (int i = 0; i < MAX_IDS; i++) begin
      if ((IDC_W'(i) < id_count) && (sc_ids[i] == craft_id)) begin
        hit = 1'b1;
      end
    end
  end

endmodule

[rtl/tmfhc_track.sv]
// ---------------------------------------------------------------------------
// tm frame header checker continuity tracker
// holds expected frame counts and error counters, builds one result per request
// ---------------------------------------------------------------------------
`include "tm_frame_header_checker_unit_assert.svh"

module tmfhc_track (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  tmfhc_pkg::item_t   item,
  input  logic               hit,
  output tmfhc_pkg::result_t res
);
  import tmfhc_pkg::*;

  logic [CNT_W-1:0] exp_master_r;
  logic [CNT_W-1:0] exp_master_nxt;
  logic [CNT_W-1:0] exp_chan_r [CHECKED_CHANNELS];
  logic [ERR_W-1:0] id_err_r,   id_err_nxt;
  logic [ERR_W-1:0] mst_err_r,  mst_err_nxt;
  logic [ERR_W-1:0] chn_err_r,  chn_err_nxt;

  logic                  is_frame;
  logic                  accepted;
  logic                  chan_checked;
  logic [CHAN_IDX_W-1:0] chan_idx;
  logic [CNT_W-1:0]      mc_inc;
  logic [CNT_W-1:0]      vc_inc;
  logic                  mgap;
  logic                  vgap;

  // decode the request
  assign is_frame     = (item.req_type == REQ_CHECK);
  assign accepted     = is_frame && hit;
  assign chan_checked = ({1'b0, item.channel_id} < (CHAN_W + 1)'(CHECKED_CHANNELS));
  assign chan_idx     = item.channel_id[CHAN_IDX_W-1:0];
  assign mc_inc       = item.master_count + 1'b1;
  assign vc_inc       = item.channel_count + 1'b1;

  // count comparisons
  assign mgap = accepted && (exp_master_r != item.master_count);
  assign vgap = accepted && chan_checked && (exp_chan_r[chan_idx] != item.channel_count);

  // next counter values
  always_comb begin
    id_err_nxt     = id_err_r;
    mst_err_nxt    = mst_err_r;
    chn_err_nxt    = chn_err_r;
    exp_master_nxt = exp_master_r;
    if (!is_frame) begin
      id_err_nxt  = '0;
      mst_err_nxt = '0;
      chn_err_nxt = '0;
    end else if (!hit) begin
      id_err_nxt = sat_inc(id_err_r);
    end else begin
      exp_master_nxt = mc_inc;
      if (mgap) mst_err_nxt = sat_inc(mst_err_r);
      if (vgap) chn_err_nxt = sat_inc(chn_err_r);
    end
  end

  // result as seen after this request
  always_comb begin
    res.frame_accepted = accepted;
    res.master_gap     = mgap;
    res.channel_gap    = vgap;
    res.id_errors      = id_err_nxt;
    res.master_errors  = mst_err_nxt;
    res.channel_errors = chn_err_nxt;
  end

  // state update once per request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_master_r <= '0;
      id_err_r     <= '0;
      mst_err_r    <= '0;
      chn_err_r    <= '0;
      for (int i = 0; i < CHECKED_CHANNELS; i++) exp_chan_r[i] <= '0;
    end else if (step) begin
      exp_master_r <= exp_master_nxt;
      id_err_r     <= id_err_nxt;
      mst_err_r    <= mst_err_nxt;
      chn_err_r    <= chn_err_nxt;
      if (accepted && chan_checked) exp_chan_r[chan_idx] <= vc_inc;
    end
  end

  `TMFHC_ASSERT_NEXT(a_clear_zeroes, step && !is_frame, (id_err_r == '0) && (mst_err_r == '0) && (chn_err_r == '0), "clear request left a counter nonzero")
  `TMFHC_ASSERT_NEXT(a_master_follow, step && accepted, exp_master_r == $past(mc_inc), "expected master count not updated")
  `TMFHC_ASSERT_NEXT(a_hold_idle, !step, $stable(id_err_r) && $stable(mst_err_r) && $stable(chn_err_r) && $stable(exp_master_r), "state moved without a request")
  `TMFHC_ASSERT_NEXT(a_no_decrease, step && is_frame, (id_err_r >= $past(id_err_r)) && (mst_err_r >= $past(mst_err_r)) && (chn_err_r >= $past(chn_err_r)), "error counter went down on a frame")

endmodule

[rtl/tm_frame_header_checker_unit.sv]
// ---------------------------------------------------------------------------
// tm frame header checker unit
// frame count continuity and spacecraft id check for decoded tm headers
// ---------------------------------------------------------------------------
// Each request (a frame header, or a clear of the error counters) yields one
// result. The block takes one request per clock while the output is not
// stalled: a request sits in the input register, is checked against the id
// table and the expected counts, and its result lands in the output register
// while the next request moves up into the input register.
// The output register stalls the pipeline only while it holds a result and
// out_tready is low.
// Configuration writes are expected only while no request is in flight.
module tm_frame_header_checker_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration
  input  logic                                cfg_we,
  input  logic [tmfhc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tmfhc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  // request channel
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // craft_id[9:0], channel_id[12:10], master_count[20:13], channel_count[28:21], zero
  input  logic [tmfhc_pkg::IN_DATA_W-1:0]     in_tdata,
  // req_type[0]
  input  logic                                in_tuser,
  // result channel
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // frame_accepted[0], master_gap[1], channel_gap[2], id_errors[18:3],
  // master_errors[34:19], channel_errors[50:35], zero
  output logic [tmfhc_pkg::OUT_DATA_W-1:0]    out_tdata
);
  import tmfhc_pkg::*;

  logic [IDC_W-1:0]                  id_count_r;
  logic [NUM_ID_REGS-1:0][ID_W-1:0]  sc_ids_r;
  logic                              in_valid_r;
  item_t                             item_r;
  logic                              out_valid_r;
  result_t                           res_r;
  result_t                           res;
  logic                              hit;
  logic                              adv;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      id_count_r <= '0;
      sc_ids_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ID_COUNT: id_count_r  <= cfg_wdata[IDC_W-1:0];
        CFG_SC_ID_0:  sc_ids_r[0] <= cfg_wdata[ID_W-1:0];
        CFG_SC_ID_1:  sc_ids_r[1] <= cfg_wdata[ID_W-1:0];
        CFG_SC_ID_2:  sc_ids_r[2] <= cfg_wdata[ID_W-1:0];
        CFG_SC_ID_3:  sc_ids_r[3] <= cfg_wdata[ID_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline handshake
  assign adv       = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || adv;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.req_type      <= req_type_t'(in_tuser);
      item_r.craft_id      <= in_tdata[9:0];
      item_r.channel_id    <= in_tdata[12:10];
      item_r.master_count  <= in_tdata[20:13];
      item_r.channel_count <= in_tdata[28:21];
    end
  end

  // id lookup
  tmfhc_id_match u_id_match (
    .id_count (id_count_r),
    .sc_ids   (sc_ids_r),
    .craft_id (item_r.craft_id),
    .hit      (hit)
  );

  // continuity check and counters
  tmfhc_track u_track (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (adv),
    .item  (item_r),
    .hit   (hit),
    .res   (res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) res_r <= res;
  end

  // result packing
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, res_r.channel_errors, res_r.master_errors, res_r.id_errors,
                       res_r.channel_gap, res_r.master_gap, res_r.frame_accepted};

endmodule
